// ===== design/bcte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcte_pkg
// Shared constants, codes and control types of the block cache tag engine.
// ============================================================================
package bcte_pkg;

    // Number of buffer entries held by the engine.
    localparam int NUM_ENTRIES = 32;
    // Bits needed to address one entry.
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    // Field widths of the request and response transactions.
    localparam int ACTION_W    = 2;
    localparam int DEVICE_W    = 8;
    localparam int BLOCK_W     = 24;
    localparam int ENTRY_W     = 5;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_GET     = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PIN     = 2'd2,
        ACT_UNPIN   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the accepted request and set the entry pointer
        logic scan;    // examine the entry under the pointer during a lookup
        logic claim;   // take the chosen victim on a miss
        logic modify;  // release, pin or unpin the addressed entry
        logic emit;    // move the pending result into the output register
    } ctrl_cmd_t;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic in_get;   // the offered request is a get
        logic match;    // the entry under the pointer holds the requested tag
        logic last;     // the pointer is at the final entry
        logic out_free; // the output register can take a result this cycle
    } ctrl_sts_t;

endpackage : bcte_pkg
`default_nettype wire

// ===== design/bcte_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcte_req_if
// Request channel: valid/ready handshake carrying one lookup or count action.
// ============================================================================
interface bcte_req_if;
    import bcte_pkg::*;

    logic                    valid;
    logic                    ready;
    action_t                 action;
    logic [DEVICE_W-1:0]     device;
    logic [BLOCK_W-1:0]      block_number;
    logic [ENTRY_W-1:0]      entry_index;
    logic [TIME_W-1:0]       now;

    modport source (
        output valid,
        output action,
        output device,
        output block_number,
        output entry_index,
        output now,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  device,
        input  block_number,
        input  entry_index,
        input  now,
        output ready
    );

endinterface : bcte_req_if
`default_nettype wire

// ===== design/bcte_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcte_rsp_if
// Response channel: valid/ready handshake carrying one result per request.
// ============================================================================
interface bcte_rsp_if;
    import bcte_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ENTRY_W-1:0]      result_entry;
    logic                    hit;
    logic                    needs_fill;
    status_t                 status;

    modport source (
        output valid,
        output result_entry,
        output hit,
        output needs_fill,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_entry,
        input  hit,
        input  needs_fill,
        input  status,
        output ready
    );

endinterface : bcte_rsp_if
`default_nettype wire

// ===== design/bcte_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcte_datapath
// Entry state, tag compare, victim search and output register of the engine.
// ============================================================================
module bcte_datapath
    import bcte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    bcte_req_if.sink       req,
    bcte_rsp_if.source     rsp,
    input  wire ctrl_cmd_t cmd,
    output ctrl_sts_t      sts
);

    // Per-entry state. All of it is read at the single pointer address.
    logic                    used_reg    [NUM_ENTRIES];
    logic                    filled_reg  [NUM_ENTRIES];
    logic [COUNT_W-1:0]      count_reg   [NUM_ENTRIES];
    logic [DEVICE_W-1:0]     tag_dev_reg [NUM_ENTRIES];
    logic [BLOCK_W-1:0]      tag_blk_reg [NUM_ENTRIES];
    logic [TIME_W-1:0]       stamp_reg   [NUM_ENTRIES];

    // Latched request.
    action_t                 req_act_reg;
    logic [DEVICE_W-1:0]     req_dev_reg;
    logic [BLOCK_W-1:0]      req_blk_reg;
    logic [ENTRY_W-1:0]      req_idx_reg;
    logic [TIME_W-1:0]       req_now_reg;

    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic                    have_reg, have_next;
    logic [IDX_W-1:0]        victim_reg, victim_next;
    logic [TIME_W-1:0]       best_reg, best_next;

    logic [ENTRY_W-1:0]      res_entry_reg, res_entry_next;
    logic                    res_hit_reg, res_hit_next;
    logic                    res_fill_reg, res_fill_next;
    status_t                 res_status_reg, res_status_next;

    logic                    out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0]      out_entry_reg;
    logic                    out_hit_reg;
    logic                    out_fill_reg;
    status_t                 out_status_reg;

    // Read port at the pointer.
    logic                    rd_used;
    logic                    rd_filled;
    logic [COUNT_W-1:0]      rd_count;
    logic [DEVICE_W-1:0]     rd_dev;
    logic [BLOCK_W-1:0]      rd_blk;
    logic [TIME_W-1:0]       rd_stamp;

    logic                    match;
    logic                    count_max;
    logic                    count_zero;
    logic [COUNT_W-1:0]      count_inc;
    logic [COUNT_W-1:0]      count_dec;
    logic                    in_range;
    logic                    candidate;

    // Write controls.
    logic [IDX_W-1:0]        wr_addr;
    logic                    count_we;
    logic [COUNT_W-1:0]      count_wdata;
    logic                    filled_we;
    logic                    tag_we;
    logic                    stamp_we;

    assign rd_used   = used_reg[ptr_reg];
    assign rd_filled = filled_reg[ptr_reg];
    assign rd_count  = count_reg[ptr_reg];
    assign rd_dev    = tag_dev_reg[ptr_reg];
    assign rd_blk    = tag_blk_reg[ptr_reg];
    assign rd_stamp  = stamp_reg[ptr_reg];

    assign match      = rd_used && (rd_dev == req_dev_reg) && (rd_blk == req_blk_reg);
    assign count_max  = (rd_count == COUNT_MAX);
    assign count_zero = (rd_count == '0);
    assign count_inc  = count_max ? rd_count : rd_count + COUNT_W'(1);
    assign count_dec  = rd_count - COUNT_W'(1);
    assign in_range   = (32'(req_idx_reg) < 32'(NUM_ENTRIES));
    assign candidate  = count_zero && (!have_reg || (rd_stamp < best_reg));

    assign sts.in_get   = (req.action == ACT_GET);
    assign sts.match    = match;
    assign sts.last     = (ptr_reg == IDX_W'(NUM_ENTRIES - 1));
    assign sts.out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        ptr_next        = ptr_reg;
        have_next       = have_reg;
        victim_next     = victim_reg;
        best_next       = best_reg;
        res_entry_next  = res_entry_reg;
        res_hit_next    = res_hit_reg;
        res_fill_next   = res_fill_reg;
        res_status_next = res_status_reg;
        wr_addr         = ptr_reg;
        count_we        = 1'b0;
        count_wdata     = count_inc;
        filled_we       = 1'b0;
        tag_we          = 1'b0;
        stamp_we        = 1'b0;

        if (cmd.load)
        begin
            ptr_next  = (req.action == ACT_GET) ? '0 : IDX_W'(req.entry_index);
            have_next = 1'b0;
        end

        if (cmd.scan)
        begin
            if (match)
            begin
                count_we        = !count_max;
                count_wdata     = count_inc;
                filled_we       = 1'b1;
                res_entry_next  = ENTRY_W'(ptr_reg);
                res_hit_next    = 1'b1;
                res_fill_next   = !rd_filled;
                res_status_next = count_max ? ST_SAT : ST_OK;
            end
            else
            begin
                if (candidate)
                begin
                    have_next   = 1'b1;
                    victim_next = ptr_reg;
                    best_next   = rd_stamp;
                end
                ptr_next = ptr_reg + IDX_W'(1);
            end
        end

        if (cmd.claim)
        begin
            wr_addr       = victim_reg;
            res_hit_next  = 1'b0;
            if (have_reg)
            begin
                count_we        = 1'b1;
                count_wdata     = COUNT_W'(1);
                filled_we       = 1'b1;
                tag_we          = 1'b1;
                stamp_we        = 1'b1;
                res_entry_next  = ENTRY_W'(victim_reg);
                res_fill_next   = 1'b1;
                res_status_next = ST_OK;
            end
            else
            begin
                res_entry_next  = '0;
                res_fill_next   = 1'b0;
                res_status_next = ST_NOFREE;
            end
        end

        if (cmd.modify)
        begin
            res_entry_next  = req_idx_reg;
            res_hit_next    = 1'b0;
            res_fill_next   = 1'b0;
            res_status_next = ST_OK;
            if (in_range)
            begin
                if (req_act_reg == ACT_PIN)
                begin
                    count_we        = !count_max;
                    count_wdata     = count_inc;
                    res_status_next = count_max ? ST_SAT : ST_OK;
                end
                else if (count_zero)
                begin
                    res_status_next = ST_UNDER;
                end
                else
                begin
                    count_we    = 1'b1;
                    count_wdata = count_dec;
                    // A release that drops the last user stamps the entry.
                    stamp_we    = (req_act_reg == ACT_RELEASE) && (count_dec == '0);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                used_reg[i]    <= 1'b0;
                filled_reg[i]  <= 1'b0;
                count_reg[i]   <= '0;
                tag_dev_reg[i] <= '0;
                tag_blk_reg[i] <= '0;
                stamp_reg[i]   <= '0;
            end
            ptr_reg       <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (count_we)
            begin
                count_reg[wr_addr] <= count_wdata;
            end
            if (filled_we)
            begin
                filled_reg[wr_addr] <= 1'b1;
            end
            if (tag_we)
            begin
                used_reg[wr_addr]    <= 1'b1;
                tag_dev_reg[wr_addr] <= req_dev_reg;
                tag_blk_reg[wr_addr] <= req_blk_reg;
            end
            if (stamp_we)
            begin
                stamp_reg[wr_addr] <= req_now_reg;
            end
            ptr_reg       <= ptr_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_act_reg <= req.action;
            req_dev_reg <= req.device;
            req_blk_reg <= req.block_number;
            req_idx_reg <= req.entry_index;
            req_now_reg <= req.now;
        end
        victim_reg     <= victim_next;
        best_reg       <= best_next;
        res_entry_reg  <= res_entry_next;
        res_hit_reg    <= res_hit_next;
        res_fill_reg   <= res_fill_next;
        res_status_reg <= res_status_next;
        if (cmd.emit)
        begin
            out_entry_reg  <= res_entry_reg;
            out_hit_reg    <= res_hit_reg;
            out_fill_reg   <= res_fill_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_entry = out_entry_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.needs_fill   = out_fill_reg;
    assign rsp.status       = out_status_reg;

    // A failed allocation reports nothing but the error.
    a_nofree_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_NOFREE))
            |-> (!rsp.hit && !rsp.needs_fill && (rsp.result_entry == '0)))
        else $error("no-free result carries entry, hit or fill");

    // A hit can only be clean or saturated.
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> ((rsp.status == ST_OK) || (rsp.status == ST_SAT)))
        else $error("hit result with an allocation or underflow status");

    // A claimed victim holds exactly one user afterwards.
    a_claim_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.claim && have_reg)
            |=> ((count_reg[$past(victim_reg)] == COUNT_W'(1)) && used_reg[$past(victim_reg)]))
        else $error("claimed entry not left with a single user");

endmodule : bcte_datapath
`default_nettype wire

// ===== design/bcte_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcte_ctrl
// Sequencer that steps the datapath through lookup, claim and count updates.
// ============================================================================
module bcte_ctrl
    import bcte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_CLAIM  = 5'b00100,
        S_MODIFY = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = sts.in_get ? S_SCAN : S_MODIFY;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.last)
                begin
                    state_next = S_CLAIM;
                end
            end
            S_CLAIM:
            begin
                cmd.claim  = 1'b1;
                state_next = S_EMIT;
            end
            S_MODIFY:
            begin
                cmd.modify = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A lookup that matches goes straight to the result.
    a_match_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && sts.match) |=> (state_reg == S_EMIT))
        else $error("matching lookup did not go to the result stage");

    // Count actions are handled in a single step after acceptance.
    a_count_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sts.in_get) |=> (state_reg == S_MODIFY))
        else $error("count action did not go to the update stage");

endmodule : bcte_ctrl
`default_nettype wire

// ===== design/block_cache_tag_lru_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// block_cache_tag_lru_engine_core
// Tag lookup and least-recently-used replacement for a set of buffer entries.
// ============================================================================
//
//  Channel  Direction  Handshake     Transaction contents
//  -------  ---------  ------------  ---------------------------------------------
//  req      in         valid/ready   action, device, block_number, entry_index, now
//  rsp      out        valid/ready   result_entry, hit, needs_fill, status
//
//  A get walks the entries one per cycle, comparing the tag and tracking the
//  oldest free entry as it goes; a hit ends the walk at the matching entry,
//  and a miss walks every entry before the victim is claimed.
//  Release, pin and unpin go through accept, update and hand-off steps.
//  One transaction is in flight at a time. The result sits in an output
//  register, so a new request is taken while the previous result waits.
//  If the response side stalls, the engine holds its next result until the
//  output register frees. Reset clears every entry at once; no clearing pass.
//
// The engine is split into a sequencer (bcte_ctrl) and a datapath
// (bcte_datapath). The sequencer owns the request handshake and issues at most one
// command per cycle; the datapath holds all entry state, the latched request,
// the victim search registers and the response register. They talk only
// through the command and status structures defined in the package.
// ============================================================================
module block_cache_tag_lru_engine_core
    import bcte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    bcte_req_if.sink       req,
    bcte_rsp_if.source     rsp
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // The sequencer decides when a request is taken and what happens to it.
    bcte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath reads the request payload and drives the whole response.
    bcte_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule : block_cache_tag_lru_engine_core
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the block cache tag and LRU replacement engine.
// A shadow copy of the entry table predicts every response; the bench runs
// directed lookups and count actions, then random workloads with idling.
// ============================================================================
module tb_top;
    import bcte_pkg::*;

    // ------------------------------------------------------------------------
    // Transaction types seen by the bench.
    // ------------------------------------------------------------------------
    typedef struct packed {
        action_t                action;
        logic [DEVICE_W-1:0]    device;
        logic [BLOCK_W-1:0]     block_number;
        logic [ENTRY_W-1:0]     entry_index;
        logic [TIME_W-1:0]      now;
    } request_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]     entry;
        logic                   hit;
        logic                   needs_fill;
        status_t                status;
    } response_t;

    // Number of random request transactions after the directed part.
    localparam int RANDOM_REQUESTS = 1800;
    // Accepted transactions per idling phase before moving to the next one.
    localparam int PHASE_LEN       = 150;
    // Cycles left after the last response in case anything stray follows.
    localparam int DRAIN_CYCLES    = 50;

    // Idling phases: none, sender only, receiver only, both together.
    localparam int unsigned SENDER_IDLE_PCT   [4] = '{0, 58, 0, 34};
    localparam int unsigned RECEIVER_STALL_PCT[4] = '{0, 0, 58, 34};

    // ------------------------------------------------------------------------
    // Clock, reset and the channels.
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    bcte_req_if req_bus();
    bcte_rsp_if rsp_bus();

    // Bench-side copies of every block input, so that each one holds a known
    // value from time zero onwards.
    logic     req_valid = 1'b0;
    request_t req_drive = '0;
    logic     rsp_ready = 1'b0;

    assign req_bus.valid        = req_valid;
    assign req_bus.action       = req_drive.action;
    assign req_bus.device       = req_drive.device;
    assign req_bus.block_number = req_drive.block_number;
    assign req_bus.entry_index  = req_drive.entry_index;
    assign req_bus.now          = req_drive.now;
    assign rsp_bus.ready        = rsp_ready;

    block_cache_tag_lru_engine_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // ------------------------------------------------------------------------
    // Shadow entry table. It is updated at the moment each request
    // transaction is accepted, so it always reflects the block's state as of
    // the last accepted request.
    // ------------------------------------------------------------------------
    bit                  slot_valid  [NUM_ENTRIES];
    bit [DEVICE_W-1:0]   slot_device [NUM_ENTRIES];
    bit [BLOCK_W-1:0]    slot_block  [NUM_ENTRIES];
    bit                  slot_filled [NUM_ENTRIES];
    bit [COUNT_W-1:0]    slot_users  [NUM_ENTRIES];
    bit [TIME_W-1:0]     slot_stamp  [NUM_ENTRIES];

    request_t  pending_requests[$];
    response_t expected_responses[$];

    int requests_queued = 0;
    int requests_taken  = 0;
    int responses_seen  = 0;
    int failures        = 0;

    // Running tick used as the timestamp of generated requests.
    logic [TIME_W-1:0] tick = '0;

    // Apply one request to the shadow table and return the response that the
    // block must give for it.
    function automatic response_t predict_response(request_t r);
        response_t res;
        bit        found;
        int        slot;
        res.entry      = '0;
        res.hit        = 1'b0;
        res.needs_fill = 1'b0;
        res.status     = ST_OK;
        found          = 1'b0;
        slot           = 0;
        if (r.action == ACT_GET)
        begin
            // Tag lookup: only entries whose tag has been written can match.
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (!found && slot_valid[i] && slot_device[i] == r.device
                    && slot_block[i] == r.block_number)
                begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found)
            begin
                res.entry      = ENTRY_W'(slot);
                res.hit        = 1'b1;
                res.needs_fill = !slot_filled[slot];
                slot_filled[slot] = 1'b1;
                if (slot_users[slot] == COUNT_MAX)
                    res.status = ST_SAT;
                else
                    slot_users[slot]++;
            end
            else
            begin
                // Oldest unused entry, strict comparison keeps the lowest
                // index on equal stamps.
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (slot_users[i] == 0 && (!found || slot_stamp[i] < slot_stamp[slot]))
                    begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (!found)
                    res.status = ST_NOFREE;
                else
                begin
                    slot_valid[slot]  = 1'b1;
                    slot_device[slot] = r.device;
                    slot_block[slot]  = r.block_number;
                    slot_users[slot]  = 1;
                    slot_stamp[slot]  = r.now;
                    slot_filled[slot] = 1'b1;
                    res.entry         = ENTRY_W'(slot);
                    res.needs_fill    = 1'b1;
                end
            end
        end
        else
        begin
            res.entry = r.entry_index;
            if (r.entry_index < NUM_ENTRIES)
            begin
                slot = r.entry_index;
                if (r.action == ACT_PIN)
                begin
                    if (slot_users[slot] == COUNT_MAX)
                        res.status = ST_SAT;
                    else
                        slot_users[slot]++;
                end
                else if (slot_users[slot] == 0)
                    res.status = ST_UNDER;
                else
                begin
                    slot_users[slot]--;
                    // Only a release that frees the entry stamps it.
                    if (r.action == ACT_RELEASE && slot_users[slot] == 0)
                        slot_stamp[slot] = r.now;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. The bus is refilled whenever it is empty or its
    // transaction has just been taken; the sender idles at random according
    // to the current phase.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_drive <= '0;
        end
        else
        begin
            if (req_valid && req_bus.ready)
            begin
                expected_responses.push_back(predict_response(req_drive));
                requests_taken++;
            end
            if (!req_valid || req_bus.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >=
                    SENDER_IDLE_PCT[(requests_taken / PHASE_LEN) % 4])
                begin
                    req_drive <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Every response transaction is compared with the
    // oldest outstanding prediction; ready is stalled at random.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid && rsp_ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("response with no request outstanding: entry %0d",
                           rsp_bus.result_entry);
                    failures++;
                end
                else
                begin
                    response_t want;
                    want = expected_responses.pop_front();
                    if (rsp_bus.result_entry !== want.entry)
                    begin
                        $error("result_entry: expected %0d, got %0d",
                               want.entry, rsp_bus.result_entry);
                        failures++;
                    end
                    if (rsp_bus.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
                        failures++;
                    end
                    if (rsp_bus.needs_fill !== want.needs_fill)
                    begin
                        $error("needs_fill: expected %0d, got %0d",
                               want.needs_fill, rsp_bus.needs_fill);
                        failures++;
                    end
                    if (rsp_bus.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        failures++;
                    end
                end
                responses_seen++;
            end
            rsp_ready <= $urandom_range(99) >=
                         RECEIVER_STALL_PCT[(responses_seen / PHASE_LEN) % 4];
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_request(action_t act, logic [DEVICE_W-1:0] dev,
                                 logic [BLOCK_W-1:0] blk, logic [ENTRY_W-1:0] idx,
                                 logic [TIME_W-1:0] stamp);
        request_t r;
        r.action       = act;
        r.device       = dev;
        r.block_number = blk;
        r.entry_index  = idx;
        r.now          = stamp;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    // Wait until every queued transaction has been accepted, so that the
    // shadow table is current; optionally also until every response is in.
    task automatic settle(bit all_responses);
        while (pending_requests.size() != 0 || req_valid)
            @(negedge clk);
        if (all_responses)
            while (expected_responses.size() != 0)
                @(negedge clk);
    endtask

    // Mostly a rising clock of ticks, now and then an arbitrary stamp so that
    // every bit of the time field is exercised and the LRU order is shaken.
    function automatic logic [TIME_W-1:0] next_tick();
        if ($urandom_range(15) == 0)
            return TIME_W'($urandom);
        tick = tick + TIME_W'($urandom_range(1, 50));
        return tick;
    endfunction

    // An entry that currently has users, or any entry if there is none.
    function automatic logic [ENTRY_W-1:0] pick_busy_slot();
        int start;
        int i;
        start = $urandom_range(NUM_ENTRIES - 1);
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            i = (start + k) % NUM_ENTRIES;
            if (slot_users[i] != 0)
                return ENTRY_W'(i);
        end
        return ENTRY_W'(start);
    endfunction

    function automatic int users_outstanding();
        int total;
        total = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
            total += slot_users[i];
        return total;
    endfunction

    // Give back every user of every entry, leaving all counts at zero.
    task automatic release_all_users();
        settle(1'b0);
        for (int i = 0; i < NUM_ENTRIES; i++)
            repeat (int'(slot_users[i]))
                queue_request(ACT_RELEASE, DEVICE_W'($urandom), BLOCK_W'($urandom),
                              ENTRY_W'(i), next_tick());
    endtask

    // A small pool of tags (40 of them for 32 entries) gives a mix of hits,
    // misses and evictions; releases and unpins go mostly to busy entries.
    task automatic working_set_burst();
        int pick;
        settle(1'b0);
        repeat ($urandom_range(8, 24))
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_request(ACT_GET, DEVICE_W'($urandom_range(3, 4)),
                              BLOCK_W'($urandom_range(0, 19)), ENTRY_W'($urandom),
                              next_tick());
            else if (pick < 80)
                queue_request(ACT_RELEASE, DEVICE_W'($urandom), BLOCK_W'($urandom),
                              pick_busy_slot(), next_tick());
            else if (pick < 90)
                queue_request(ACT_PIN, DEVICE_W'($urandom), BLOCK_W'($urandom),
                              pick_busy_slot(), next_tick());
            else
                queue_request(ACT_UNPIN, DEVICE_W'($urandom), BLOCK_W'($urandom),
                              pick_busy_slot(), next_tick());
        end
    endtask

    // More fresh tags than entries: the table fills and the last gets find
    // no free entry. Everything is then handed back.
    task automatic exhaust_entries();
        settle(1'b0);
        repeat ($urandom_range(NUM_ENTRIES + 1, NUM_ENTRIES + 4))
            queue_request(ACT_GET, DEVICE_W'($urandom), BLOCK_W'($urandom),
                          ENTRY_W'($urandom), next_tick());
        release_all_users();
    endtask

    // Drive one entry's count up to the ceiling by pins and gets, push past
    // it, then bring it back to zero and one step beyond.
    task automatic saturation_storm();
        int e;
        settle(1'b0);
        e = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (e < 0 && slot_valid[i])
                e = i;
        if (e < 0)
            e = $urandom_range(NUM_ENTRIES - 1);
        repeat (254 - int'(slot_users[e]))
            queue_request(ACT_PIN, DEVICE_W'($urandom), BLOCK_W'($urandom),
                          ENTRY_W'(e), next_tick());
        // The last two of these find the count already at the ceiling.
        repeat (3)
        begin
            if (slot_valid[e])
                queue_request(ACT_GET, slot_device[e], slot_block[e], ENTRY_W'($urandom),
                              next_tick());
            else
                queue_request(ACT_PIN, DEVICE_W'($urandom), BLOCK_W'($urandom),
                              ENTRY_W'(e), next_tick());
        end
        queue_request(ACT_PIN, DEVICE_W'($urandom), BLOCK_W'($urandom), ENTRY_W'(e),
                      next_tick());
        settle(1'b0);
        repeat (int'(slot_users[e]) - 1)
            queue_request(ACT_UNPIN, DEVICE_W'($urandom), BLOCK_W'($urandom),
                          ENTRY_W'(e), next_tick());
        queue_request(ACT_RELEASE, DEVICE_W'($urandom), BLOCK_W'($urandom), ENTRY_W'(e),
                      next_tick());
        queue_request(ACT_UNPIN, DEVICE_W'($urandom), BLOCK_W'($urandom), ENTRY_W'(e),
                      next_tick());
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence and end of test.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int  target;
        int  pick;
        bit  storm_done;
        storm_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);

        // Directed part. A first get on an empty table claims entry 0, the
        // same tag then hits, and a tag at the field extremes goes to the
        // next entry because equal stamps favour the lowest index.
        queue_request(ACT_GET,     8'h00, 24'h000000, 5'd31, 32'h0000_0000);
        queue_request(ACT_GET,     8'h00, 24'h000000, 5'd0,  32'h0000_0005);
        queue_request(ACT_GET,     8'hFF, 24'hFFFFFF, 5'd0,  32'hFFFF_FFFF);
        // Release down to zero stamps the entry; one more underflows.
        queue_request(ACT_RELEASE, 8'hFF, 24'hFFFFFF, 5'd0,  32'd10);
        queue_request(ACT_RELEASE, 8'hFF, 24'hFFFFFF, 5'd0,  32'd11);
        queue_request(ACT_RELEASE, 8'h00, 24'h000000, 5'd0,  32'd12);
        // Count actions on an entry whose tag was never written.
        queue_request(ACT_PIN,     8'h00, 24'h000000, 5'd31, 32'd13);
        queue_request(ACT_UNPIN,   8'hFF, 24'hFFFFFF, 5'd31, 32'd14);
        queue_request(ACT_UNPIN,   8'h00, 24'h000000, 5'd31, 32'd15);
        // An unused entry keeps its tag: a pin then a get hit on it.
        queue_request(ACT_PIN,     8'h5A, 24'hA5A5A5, 5'd0,  32'd16);
        queue_request(ACT_GET,     8'h00, 24'h000000, 5'd17, 32'd17);
        // Entry 1 freed with the newest possible stamp, so a miss skips it
        // for the older entry 2.
        queue_request(ACT_RELEASE, 8'h00, 24'h000000, 5'd1,  32'hFFFF_FFFF);
        queue_request(ACT_GET,     8'h00, 24'h000001, 5'd1,  32'd20);
        // A hit on an entry with no users: the count goes back to one and no
        // fill is needed.
        queue_request(ACT_GET,     8'hFF, 24'hFFFFFF, 5'd2,  32'd21);
        // Unpin to zero leaves the stamp alone.
        queue_request(ACT_UNPIN,   8'h00, 24'h000000, 5'd0,  32'd22);
        queue_request(ACT_UNPIN,   8'h00, 24'h000000, 5'd0,  32'd23);
        queue_request(ACT_RELEASE, 8'h00, 24'h000000, 5'd2,  32'd0);
        tick = 32'd100;

        // Sender holds off until every response is back.
        settle(1'b1);

        target = requests_queued + RANDOM_REQUESTS;
        while (requests_queued < target)
        begin
            if (!storm_done && requests_queued > 400)
            begin
                saturation_storm();
                storm_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    working_set_burst();
                else if (pick < 75)
                    exhaust_entries();
                else
                begin
                    // Unshaped requests: any action, any field values.
                    repeat ($urandom_range(6, 16))
                        queue_request(action_t'($urandom_range(3)), DEVICE_W'($urandom),
                                      BLOCK_W'($urandom), ENTRY_W'($urandom),
                                      TIME_W'($urandom));
                end
            end
            // Keep counts low enough that free entries stay available.
            if (users_outstanding() > 48)
                release_all_users();
            if ($urandom_range(9) == 0)
                settle(1'b1);
        end

        settle(1'b1);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule : tb_top
